// ----- rtl/core/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared constants and types for the command line tokenizer: character
// codes, store and token limits, front-end state and the queued command.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  // Line store and token limits
  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned MAX_TOKENS  = 16;
  localparam int unsigned BW_W        = $clog2(STORE_BYTES);
  localparam int unsigned TC_W        = $clog2(MAX_TOKENS);

  // Field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned TOTAL_W = 4;

  // Results per character, at most
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_W   = $clog2(MAX_RES);

  // Command queue depth; must be a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_BAR   = 8'h7C;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;

  // Per-line parse state
  typedef struct packed {
    logic            in_word;
    logic            quoted;
    logic            pending_gt;
    logic [BW_W-1:0] bytes_written;
    logic [TC_W-1:0] token_count;
    logic            halted;
    logic            word_empty;
  } state_t;

  // One classified character: up to three results
  typedef struct packed {
    logic [MAX_RES-1:0][CH_W-1:0] bytes;
    logic [MAX_RES-1:0]           starts;
    logic [RES_W-1:0]             last_idx;
    logic                         done;
    logic [TOTAL_W-1:0]           total;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

// ----- rtl/core/clt_front.sv -----
// ----------------------------------------------------------------------------
// clt_front
// Accepts one character per cycle while accept_i is high, runs the tokenizer state and packs the
// results the character causes into one command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           ch_i,
  output clt_pkg::push_t            push_o
);
  import clt_pkg::*;

  state_t st_q, st_d;
  cmd_t   cmd;
  logic   [RES_W:0] n_cnt;

  // Count one stored byte; close everything once the store is full
  function automatic state_t emit_upd(state_t s);
    state_t r;
    r = s;
    r.bytes_written = s.bytes_written + BW_W'(1);
    if (r.bytes_written >= BW_W'(STORE_BYTES - 1)) begin
      r.halted     = 1'b1;
      r.in_word    = 1'b0;
      r.quoted     = 1'b0;
      r.pending_gt = 1'b0;
      r.word_empty = 1'b0;
    end
    return r;
  endfunction

  // Classify the character and build its results
  always_comb begin
    logic blank;
    logic stop;
    logic s;
    st_d     = st_q;
    cmd      = '0;
    n_cnt    = '0;
    stop     = 1'b0;
    s        = 1'b0;
    blank    = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    if (ch_i == CH_NUL) begin
      if (!st_d.halted && (st_d.pending_gt || st_d.in_word)) begin
        cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
        cmd.starts[n_cnt[RES_W-1:0]] = st_d.in_word && st_d.word_empty;
        n_cnt = n_cnt + 1'b1;
      end
      // End-of-line record
      cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
      cmd.starts[n_cnt[RES_W-1:0]] = 1'b0;
      n_cnt     = n_cnt + 1'b1;
      cmd.done  = 1'b1;
      cmd.total = TOTAL_W'(st_d.token_count);
      st_d      = '0;
    end else if (!st_d.halted) begin
      // Resolve a pending '>' first
      if (st_d.pending_gt) begin
        st_d.pending_gt = 1'b0;
        if (ch_i == CH_GT) begin
          cmd.bytes[n_cnt[RES_W-1:0]]  = CH_GT;
          cmd.starts[n_cnt[RES_W-1:0]] = 1'b0;
          n_cnt = n_cnt + 1'b1;
          st_d  = emit_upd(st_d);
          if (!st_d.halted) begin
            cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
            cmd.starts[n_cnt[RES_W-1:0]] = 1'b0;
            n_cnt = n_cnt + 1'b1;
            st_d  = emit_upd(st_d);
          end
          stop = 1'b1;
        end else begin
          cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
          cmd.starts[n_cnt[RES_W-1:0]] = 1'b0;
          n_cnt = n_cnt + 1'b1;
          st_d  = emit_upd(st_d);
          if (st_d.halted) stop = 1'b1;
        end
      end
      // Continue or close the current word
      if (!stop && st_d.in_word) begin
        if (ch_i == CH_QUOTE) begin
          st_d.quoted = !st_d.quoted;
          stop = 1'b1;
        end else if (!st_d.quoted && (blank || ch_i == CH_GT || ch_i == CH_BAR)) begin
          s               = st_d.word_empty;
          st_d.in_word    = 1'b0;
          st_d.word_empty = 1'b0;
          cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
          cmd.starts[n_cnt[RES_W-1:0]] = s;
          n_cnt = n_cnt + 1'b1;
          st_d  = emit_upd(st_d);
          if (st_d.halted || blank) stop = 1'b1;
        end else begin
          s               = st_d.word_empty;
          st_d.word_empty = 1'b0;
          cmd.bytes[n_cnt[RES_W-1:0]]  = ch_i;
          cmd.starts[n_cnt[RES_W-1:0]] = s;
          n_cnt = n_cnt + 1'b1;
          st_d  = emit_upd(st_d);
          stop  = 1'b1;
        end
      end
      // Start a new token
      if (!stop && !blank) begin
        if (st_d.token_count >= TC_W'(MAX_TOKENS - 1)) begin
          st_d.halted = 1'b1;
        end else begin
          st_d.token_count = st_d.token_count + TC_W'(1);
          if (ch_i == CH_GT) begin
            cmd.bytes[n_cnt[RES_W-1:0]]  = CH_GT;
            cmd.starts[n_cnt[RES_W-1:0]] = 1'b1;
            n_cnt = n_cnt + 1'b1;
            st_d  = emit_upd(st_d);
            if (!st_d.halted) st_d.pending_gt = 1'b1;
          end else if (ch_i == CH_BAR) begin
            cmd.bytes[n_cnt[RES_W-1:0]]  = CH_BAR;
            cmd.starts[n_cnt[RES_W-1:0]] = 1'b1;
            n_cnt = n_cnt + 1'b1;
            st_d  = emit_upd(st_d);
            if (!st_d.halted) begin
              cmd.bytes[n_cnt[RES_W-1:0]]  = CH_NUL;
              cmd.starts[n_cnt[RES_W-1:0]] = 1'b0;
              n_cnt = n_cnt + 1'b1;
              st_d  = emit_upd(st_d);
            end
          end else begin
            st_d.in_word    = 1'b1;
            st_d.quoted     = 1'b0;
            st_d.word_empty = 1'b1;
            if (ch_i == CH_QUOTE) begin
              st_d.quoted = 1'b1;
            end else begin
              st_d.word_empty = 1'b0;
              cmd.bytes[n_cnt[RES_W-1:0]]  = ch_i;
              cmd.starts[n_cnt[RES_W-1:0]] = 1'b1;
              n_cnt = n_cnt + 1'b1;
              st_d  = emit_upd(st_d);
            end
          end
        end
      end
    end
    cmd.last_idx = RES_W'(n_cnt - 1'b1);
  end

  // Hold the parse state between characters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  // Push only characters that cause results
  assign push_o.push = accept_i && (n_cnt != '0);
  assign push_o.cmd  = cmd;

endmodule

`default_nettype wire

// ----- rtl/core/clt_queue.sv -----
// ----------------------------------------------------------------------------
// clt_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire clt_pkg::push_t  push_i,
  input  wire logic            pop_i,
  output clt_pkg::head_t       head_o,
  output logic                 full_o
);
  import clt_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  // Write the incoming command
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)       rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i.push && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (!push_i.push && pop_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

// ----- rtl/core/clt_back.sv -----
// ----------------------------------------------------------------------------
// clt_back
// Plays out the queued command one result per transfer and marks the last
// result of each character.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire clt_pkg::head_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 token_start_o,
  output logic                 line_done_o,
  output logic [3:0]           token_total_o,
  output logic                 run_last_o
);
  import clt_pkg::*;

  logic [RES_W-1:0] idx_q, idx_d;
  logic             last;
  logic             xfer;

  assign last = (idx_q == head_i.cmd.last_idx);
  assign xfer = head_i.valid && !out_stall_i;
  assign pop_o = xfer && last;

  // Step through results of the head command
  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = last ? '0 : idx_q + RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign out_valid_o   = head_i.valid;
  assign out_byte_o    = head_i.cmd.bytes[idx_q];
  assign token_start_o = head_i.cmd.starts[idx_q];
  assign line_done_o   = head_i.cmd.done && last;
  assign token_total_o = line_done_o ? head_i.cmd.total : '0;
  assign run_last_o    = last;

endmodule

`default_nettype wire

// ----- rtl/core/command_line_tokenizer.sv -----
// A character's command is registered in the queue before its results show.
// Throughput: one character per cycle while each causes at most one result
// and the output is not stalled; from the two-entry queue, the back end plays
// out one result per cycle unless stalled, popping a character after its last.
// Reset: all line state clears at once and the command queue empties.
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Streaming tokenizer for shell command lines: words, quotes, '>', '>>'
// and '|' tokens, with zero terminators and an end-of-line record.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            token_start_o,
  output logic            line_done_o,
  output logic [3:0]      token_total_o,
  output logic            run_last_o
);
  import clt_pkg::*;

  push_t push;
  head_t head;
  logic  pop;
  logic  full;
  logic  accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  clt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .push_o   (push)
  );

  clt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  clt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .token_start_o (token_start_o),
    .line_done_o   (line_done_o),
    .token_total_o (token_total_o),
    .run_last_o    (run_last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/clt_checker.sv -----
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks for the command line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] ch_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       token_start_o,
  input wire logic       line_done_o,
  input wire logic [3:0] token_total_o,
  input wire logic       run_last_o
);

  // A stalled character stays offered with the same code
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(ch_i))
    else $error("character changed while stalled");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(token_start_o)
      && $stable(line_done_o) && $stable(token_total_o) && $stable(run_last_o))
    else $error("result payload changed while stalled");

  // The end-of-line record is the last result of its character and carries no byte
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> run_last_o && out_byte_o == 8'h00 && !token_start_o)
    else $error("malformed end-of-line record");

  // A token count shows only on the end-of-line record
  a_total_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_total_o != 4'd0 |-> line_done_o)
    else $error("token count outside end-of-line record");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

`default_nettype wire
